>>> design/buq_pkg.sv
// shared types and constants for the branch update ring queue
package buq_pkg;

  // default queue depth
  localparam int unsigned DEPTH_DEF = 64;

  // payload field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned TGT_W     = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CNT_OUT_W = 7;

  // stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 80;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_SET   = 3'd1,
    OP_POP   = 3'd2,
    OP_DROP  = 3'd3,
    OP_FLUSH = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // write strobes from control to storage
  typedef struct packed {
    logic wr_target;
    logic wr_dir;
  } mem_wr_t;

  // per-transaction queue status
  typedef struct packed {
    logic                 read_valid;
    logic                 is_full;
    logic                 is_empty;
    logic [CNT_OUT_W-1:0] entry_count;
    status_e              status;
  } res_t;

endpackage

>>> design/branch_update_ring_queue.sv
// top level of the branch update ring queue
//
//  channel  dir  tdata (low bit up)                              tuser
//  s_axis   in   target[63:0] direction[64] slot[70:65] pad[71]   op[2:0]
//  m_axis   out  read_target[63:0] read_direction[64] read_valid[65]
//                is_full[66] is_empty[67] entry_count[74:68]
//                status[76:75] pad[79:77]                         -
//
// one transaction per cycle sustained while m_axis does not stall; the result
// is valid once the accepted input has passed both registers (input register,
// then state update and memory read into the result register)
// reset empties the queue; the entry memories are not cleared
// a stall on m_axis holds both stages; s_axis stays ready while the
// input register is empty or can move on
module branch_update_ring_queue #(
  parameter int unsigned DEPTH = buq_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [buq_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // target, direction, slot
  input  logic [buq_pkg::OP_W-1:0]          s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [buq_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // read_target, read_direction,
                                                           // read_valid, is_full, is_empty,
                                                           // entry_count, status
);
  import buq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic               in_valid_q;
  logic [OP_W-1:0]    op_q;
  logic [TGT_W-1:0]   target_q;
  logic               dir_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               out_valid_q;
  res_t               res_q;
  res_t               res;
  mem_wr_t            wr;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   waddr;
  logic [TGT_W-1:0]   rtarget;
  logic               rdir;
  logic               adv;
  logic               in_acc;

  // pipeline flow control
  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= s_axis_tuser;
      target_q <= s_axis_tdata[TGT_W-1:0];
      dir_q    <= s_axis_tdata[TGT_W];
      slot_q   <= s_axis_tdata[TGT_W+SLOT_W:TGT_W+1];
    end
  end

  // queue control
  buq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .op_i    (op_q),
    .slot_i  (slot_q),
    .head_o  (head),
    .waddr_o (waddr),
    .wr_o    (wr),
    .res_o   (res)
  );

  // entry storage
  buq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .raddr_i   (head),
    .waddr_i   (waddr),
    .wr_i      (wr),
    .wtarget_i (target_q),
    .wdir_i    (dir_q),
    .rtarget_o (rtarget),
    .rdir_o    (rdir)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  // result packing, read fields zero unless a pop returned an entry
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          res_q.status,
                          res_q.entry_count,
                          res_q.is_empty,
                          res_q.is_full,
                          res_q.read_valid,
                          rdir & res_q.read_valid,
                          rtarget & {TGT_W{res_q.read_valid}}};

  // a stage move always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) adv |=> m_axis_tvalid)
    else $error("result lost after stage move");

  // a waiting result is not overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !adv)
    else $error("stalled result overwritten");

  // a full input register with a free output moves on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> adv)
    else $error("pipeline bubble with free output");

endmodule

>>> design/buq_ctrl.sv
// head, tail and fill count control with per-operation status
module buq_ctrl #(
  parameter int unsigned DEPTH = buq_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [buq_pkg::OP_W-1:0]        op_i,
  input  logic [buq_pkg::SLOT_W-1:0]      slot_i,
  output logic [$clog2(DEPTH)-1:0]        head_o,
  output logic [$clog2(DEPTH)-1:0]        waddr_o,
  output buq_pkg::mem_wr_t                wr_o,
  output buq_pkg::res_t                   res_o
);
  import buq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_target, wr_dir;
  logic             slot_ok;

  // pointer increment with wrap
  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign slot_ok = (32'(slot_i) < 32'(DEPTH));

  // operation decode, next pointer state and status flags after the operation
  always_comb begin
    head_d            = head_q;
    tail_d            = tail_q;
    cnt_d             = cnt_q;
    wr_target         = 1'b0;
    wr_dir            = 1'b0;
    waddr_o           = tail_q;
    res_o.read_valid  = 1'b0;
    res_o.status      = ST_OK;
    unique case (op_e'(op_i)) inside
      OP_PUSH: begin
        if (cnt_q == CNT_FULL) begin
          res_o.status = ST_FULL;
        end else begin
          wr_target = 1'b1;
          wr_dir    = 1'b1;
          tail_d    = wrap_inc(tail_q);
          cnt_d     = CNT_W'(cnt_q + 1'b1);
        end
      end
      OP_SET: begin
        waddr_o = PTR_W'(slot_i);
        wr_dir  = slot_ok;
      end
      OP_POP, OP_DROP: begin
        if (cnt_q == '0) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.read_valid = (op_e'(op_i) == OP_POP);
          head_d           = wrap_inc(head_q);
          cnt_d            = CNT_W'(cnt_q - 1'b1);
        end
      end
      OP_FLUSH: begin
        head_d = '0;
        tail_d = '0;
        cnt_d  = '0;
      end
      default: begin
      end
    endcase
    res_o.is_full     = (cnt_d == CNT_FULL);
    res_o.is_empty    = (cnt_d == '0);
    res_o.entry_count = CNT_OUT_W'(cnt_d);
  end

  // write strobes only on a stage move
  always_comb begin
    wr_o.wr_target    = en_i & wr_target;
    wr_o.wr_dir       = en_i & wr_dir;
  end

  assign head_o = head_q;

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (en_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_FULL)
    else $error("fill count beyond depth");

  // empty or full queue has coinciding pointers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_FULL) |-> head_q == tail_q)
    else $error("pointers disagree with fill count");

  // an accepted push grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && op_e'(op_i) == OP_PUSH && res_o.status == ST_OK)
      |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
    else $error("push did not grow fill count");

  // an ignored operation leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.status != ST_OK) |=> $stable(cnt_q))
    else $error("ignored operation changed fill count");

endmodule

>>> design/buq_store.sv
// entry storage: target and direction memories with registered read
module buq_store #(
  parameter int unsigned DEPTH = buq_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]    raddr_i,
  input  logic [$clog2(DEPTH)-1:0]    waddr_i,
  input  buq_pkg::mem_wr_t            wr_i,
  input  logic [buq_pkg::TGT_W-1:0]   wtarget_i,
  input  logic                        wdir_i,
  output logic [buq_pkg::TGT_W-1:0]   rtarget_o,
  output logic                        rdir_o
);
  import buq_pkg::*;

  logic [TGT_W-1:0] tgt_mem_q [DEPTH];
  logic             dir_mem_q [DEPTH];

  // target memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_target) begin
      tgt_mem_q[waddr_i] <= wtarget_i;
    end
    if (rd_en_i) begin
      rtarget_o <= tgt_mem_q[raddr_i];
    end
  end

  // direction memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_dir) begin
      dir_mem_q[waddr_i] <= wdir_i;
    end
    if (rd_en_i) begin
      rdir_o <= dir_mem_q[raddr_i];
    end
  end

endmodule
